@@ rtl/xprf_pkg.sv @@
// Package for the x86-64 partial register file.
// Holds operation and part codes, sizes and the types shared by the decoder,
// the register array and the top level. Depends on nothing.
package xprf_pkg;

    localparam int NUM_REGS  = 17;
    localparam int WORD_W    = 64;
    localparam int OP_W      = 2;
    localparam int IDX_W     = 5;
    localparam int PART_W    = 3;
    localparam int BITS_W    = 7;

    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [PART_W-1:0] PART_LOW_BYTE  = 3'd0;
    localparam logic [PART_W-1:0] PART_HIGH_BYTE = 3'd1;
    localparam logic [PART_W-1:0] PART_WORD      = 3'd2;
    localparam logic [PART_W-1:0] PART_DWORD     = 3'd3;
    localparam logic [PART_W-1:0] PART_QWORD     = 3'd4;

    localparam logic [IDX_W-1:0] IDX_LAST_LEGACY = 5'd3;
    localparam logic [IDX_W-1:0] IDX_RIP         = 5'd16;
    localparam logic [IDX_W-1:0] IDX_LIMIT       = 5'd17;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] mask;
        logic [BITS_W-1:0] bits;
        logic              zero_ext;
    } decode_t;

    typedef struct packed {
        logic              write;
        logic              clear;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] data;
        logic              zero_ext;
    } wr_req_t;

endpackage

@@ rtl/xprf_decode.sv @@
// Decoder for an index and part pair of the partial register file.
// Produces the part mask, its bit count and whether the pair names a register.
// Depends on xprf_pkg.
module xprf_decode (
    input  logic [xprf_pkg::IDX_W-1:0]  idx,
    input  logic [xprf_pkg::PART_W-1:0] part,
    output xprf_pkg::decode_t           dec
);
    import xprf_pkg::*;

    logic pair_ok;

    always_comb
    begin
        pair_ok = (idx < IDX_LIMIT) && (part <= PART_QWORD);
        if ((part == PART_HIGH_BYTE) && (idx > IDX_LAST_LEGACY))
        begin
            pair_ok = 1'b0;
        end
        if ((part == PART_LOW_BYTE) && (idx == IDX_RIP))
        begin
            pair_ok = 1'b0;
        end

        dec.valid    = pair_ok;
        dec.zero_ext = (part == PART_DWORD);
        case (part)
            PART_LOW_BYTE:
            begin
                dec.mask = 64'h0000_0000_0000_00FF;
                dec.bits = 7'd8;
            end
            PART_HIGH_BYTE:
            begin
                dec.mask = 64'h0000_0000_0000_FF00;
                dec.bits = 7'd8;
            end
            PART_WORD:
            begin
                dec.mask = 64'h0000_0000_0000_FFFF;
                dec.bits = 7'd16;
            end
            PART_DWORD:
            begin
                dec.mask = 64'h0000_0000_FFFF_FFFF;
                dec.bits = 7'd32;
            end
            default:
            begin
                dec.mask = {WORD_W{1'b1}};
                dec.bits = 7'd64;
            end
        endcase
    end

endmodule

@@ rtl/xprf_regs.sv @@
// Register array of the partial register file: seventeen 64-bit words and
// their written marks, with masked merge, zero-extending write and clear.
// Depends on xprf_pkg.
module xprf_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  xprf_pkg::wr_req_t           req,
    input  logic [xprf_pkg::IDX_W-1:0]  rd_idx,
    output logic [xprf_pkg::WORD_W-1:0] rd_word,
    output logic                        rd_mark
);
    import xprf_pkg::*;

    logic [WORD_W-1:0]   words_reg [NUM_REGS];
    logic [NUM_REGS-1:0] marks_reg;
    logic [WORD_W-1:0]   old_word;
    logic [WORD_W-1:0]   merged_next;
    logic                wr_in_range;
    logic                rd_in_range;

    assign wr_in_range = (req.idx < IDX_LIMIT);
    assign rd_in_range = (rd_idx < IDX_LIMIT);
    assign old_word    = wr_in_range ? words_reg[req.idx] : '0;
    assign merged_next = ((req.zero_ext ? '0 : (old_word & ~req.mask))) | (req.data & req.mask);

    assign rd_word = rd_in_range ? words_reg[rd_idx] : '0;
    assign rd_mark = rd_in_range ? marks_reg[rd_idx] : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                words_reg[i] <= '0;
            end
            marks_reg <= '0;
        end
        else if (req.clear)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                words_reg[i] <= '0;
            end
            marks_reg <= '0;
        end
        else if (req.write && wr_in_range)
        begin
            words_reg[req.idx] <= merged_next;
            marks_reg[req.idx] <= 1'b1;
        end
    end

endmodule

@@ rtl/x86_partial_register_file.sv @@
// An x86-64 register file of sixteen general registers and the instruction
// pointer, addressed as low byte, high byte, word, dword or qword parts.
// Accesses are taken in order, one transfer per cycle while results are
// taken. Each item is decoded and applied to the array during its stay in
// the input register, and its result is written into the result register
// as the item leaves the input register, once advance is high. A result that
// is not taken holds the next item in the input register and drops in_ready.
// A read sees every earlier write, since all accesses to the array happen in
// the same stage. Depends on xprf_pkg, xprf_decode and xprf_regs.
module x86_partial_register_file (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [xprf_pkg::OP_W-1:0]     operation,
    input  logic [xprf_pkg::IDX_W-1:0]    reg_index,
    input  logic [xprf_pkg::PART_W-1:0]   part,
    input  logic [xprf_pkg::WORD_W-1:0]   write_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [xprf_pkg::WORD_W-1:0]   read_value,
    output logic                          known,
    output logic [xprf_pkg::BITS_W-1:0]   width_bits,
    output logic                          bad_register
);
    import xprf_pkg::*;

    logic               s1_valid_reg;
    logic [OP_W-1:0]    s1_op_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [PART_W-1:0]  s1_part_reg;
    logic [WORD_W-1:0]  s1_value_reg;

    logic               out_valid_reg;
    logic [WORD_W-1:0]  read_value_reg;
    logic               known_reg;
    logic [BITS_W-1:0]  width_bits_reg;
    logic               bad_register_reg;

    logic [WORD_W-1:0]  read_value_next;
    logic               known_next;
    logic [BITS_W-1:0]  width_bits_next;
    logic               bad_register_next;

    logic               advance;
    logic               s1_fire;
    logic               is_access;
    decode_t            dec;
    wr_req_t            req;
    logic [WORD_W-1:0]  rd_word;
    logic               rd_mark;

    assign advance  = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    xprf_decode u_decode (
        .idx  (s1_idx_reg),
        .part (s1_part_reg),
        .dec  (dec)
    );

    always_comb
    begin
        req.write    = s1_fire && (s1_op_reg == OP_WRITE) && dec.valid;
        req.clear    = s1_fire && (s1_op_reg == OP_CLEAR);
        req.idx      = s1_idx_reg;
        req.mask     = dec.mask;
        req.data     = s1_value_reg;
        req.zero_ext = dec.zero_ext;
    end

    xprf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_idx  (s1_idx_reg),
        .rd_word (rd_word),
        .rd_mark (rd_mark)
    );

    assign is_access = (s1_op_reg == OP_READ) || (s1_op_reg == OP_WRITE);

    always_comb
    begin
        read_value_next   = '0;
        known_next        = 1'b0;
        width_bits_next   = '0;
        bad_register_next = 1'b0;
        if (is_access && !dec.valid)
        begin
            bad_register_next = 1'b1;
        end
        else if (s1_op_reg == OP_READ)
        begin
            read_value_next = rd_word & dec.mask;
            known_next      = rd_mark;
            width_bits_next = dec.bits;
        end
        else if (s1_op_reg == OP_WRITE)
        begin
            known_next      = 1'b1;
            width_bits_next = dec.bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_op_reg    <= operation;
            s1_idx_reg   <= reg_index;
            s1_part_reg  <= part;
            s1_value_reg <= write_value;
        end
        if (s1_fire)
        begin
            read_value_reg   <= read_value_next;
            known_reg        <= known_next;
            width_bits_reg   <= width_bits_next;
            bad_register_reg <= bad_register_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_value   = read_value_reg;
    assign known        = known_reg;
    assign width_bits   = width_bits_reg;
    assign bad_register = bad_register_reg;

endmodule

@@ tb/tb_x86_partial_register_file.sv @@
// Testbench for the x86-64 partial register file, driven through valid/ready.
// Predicts every result from its own copy of the register words and written
// marks, and checks each output transfer. Depends on xprf_pkg and the top level.
`timescale 1ns / 100ps

module tb_x86_partial_register_file;

    import xprf_pkg::*;

    localparam logic [IDX_W-1:0] IDX_RAX = 5'd0;
    localparam logic [IDX_W-1:0] IDX_RBX = 5'd1;
    localparam logic [IDX_W-1:0] IDX_RSP = 5'd7;
    localparam logic [IDX_W-1:0] IDX_R8  = 5'd8;
    localparam logic [IDX_W-1:0] IDX_R15 = 5'd15;

    localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic              known;
        logic [BITS_W-1:0] width_bits;
        logic              bad_register;
    } access_result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     operation;
    logic [IDX_W-1:0]    reg_index;
    logic [PART_W-1:0]   part;
    logic [WORD_W-1:0]   write_value;
    logic                out_valid;
    logic                out_ready;
    logic [WORD_W-1:0]   read_value;
    logic                known;
    logic [BITS_W-1:0]   width_bits;
    logic                bad_register;

    logic [WORD_W-1:0]   gpr_words [NUM_REGS];
    logic [NUM_REGS-1:0] gpr_written;
    access_result_t      expected_results [$];
    int                  error_count;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    x86_partial_register_file uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .reg_index    (reg_index),
        .part         (part),
        .write_value  (write_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_value   (read_value),
        .known        (known),
        .width_bits   (width_bits),
        .bad_register (bad_register)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic access_result_t predict_access(
        input logic [OP_W-1:0]   op,
        input logic [IDX_W-1:0]  idx,
        input logic [PART_W-1:0] prt,
        input logic [WORD_W-1:0] val
    );
        access_result_t    res;
        logic [WORD_W-1:0] mask;
        logic [BITS_W-1:0] bits;
        logic              legal;
        begin
            res  = '0;
            mask = '0;
            bits = '0;
            legal = (idx < IDX_LIMIT) && (prt <= PART_QWORD)
                && !(prt == PART_HIGH_BYTE && idx > IDX_LAST_LEGACY)
                && !(prt == PART_LOW_BYTE && idx == IDX_RIP);
            case (prt)
                PART_LOW_BYTE:
                begin
                    mask = 64'h0000_0000_0000_00FF;
                    bits = 7'd8;
                end
                PART_HIGH_BYTE:
                begin
                    mask = 64'h0000_0000_0000_FF00;
                    bits = 7'd8;
                end
                PART_WORD:
                begin
                    mask = 64'h0000_0000_0000_FFFF;
                    bits = 7'd16;
                end
                PART_DWORD:
                begin
                    mask = 64'h0000_0000_FFFF_FFFF;
                    bits = 7'd32;
                end
                default:
                begin
                    mask = ALL_ONES;
                    bits = 7'd64;
                end
            endcase
            if (op == OP_CLEAR)
            begin
                gpr_words   = '{default: '0};
                gpr_written = '0;
            end
            else if (op == OP_READ || op == OP_WRITE)
            begin
                if (!legal)
                    res.bad_register = 1'b1;
                else if (op == OP_READ)
                begin
                    res.read_value = gpr_words[idx] & mask;
                    res.known      = gpr_written[idx];
                    res.width_bits = bits;
                end
                else
                begin
                    if (prt == PART_DWORD)
                        gpr_words[idx] = val & mask;
                    else
                        gpr_words[idx] = (gpr_words[idx] & ~mask) | (val & mask);
                    gpr_written[idx] = 1'b1;
                    res.known        = 1'b1;
                    res.width_bits   = bits;
                end
            end
            return res;
        end
    endfunction

    task automatic send_access(
        input logic [OP_W-1:0]   op,
        input logic [IDX_W-1:0]  idx,
        input logic [PART_W-1:0] prt,
        input logic [WORD_W-1:0] val
    );
        begin
            while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid    <= 1'b1;
            operation   <= op;
            reg_index   <= idx;
            part        <= prt;
            write_value <= val;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            expected_results.push_back(predict_access(op, idx, prt, val));
        end
    endtask

    task automatic wait_until_drained;
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (expected_results.size() != 0)
                @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        access_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no access outstanding");
                error_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (read_value !== exp_res.read_value)
                begin
                    $error("read_value: expected %h, got %h", exp_res.read_value, read_value);
                    error_count++;
                end
                if (known !== exp_res.known)
                begin
                    $error("known: expected %b, got %b", exp_res.known, known);
                    error_count++;
                end
                if (width_bits !== exp_res.width_bits)
                begin
                    $error("width_bits: expected %0d, got %0d", exp_res.width_bits, width_bits);
                    error_count++;
                end
                if (bad_register !== exp_res.bad_register)
                begin
                    $error("bad_register: expected %b, got %b",
                        exp_res.bad_register, bad_register);
                    error_count++;
                end
            end
        end
    end

    task automatic test_reset_contents;
        begin
            send_access(OP_READ, IDX_RAX, PART_QWORD, ALL_ONES);
            send_access(OP_READ, IDX_RIP, PART_QWORD, '0);
        end
    endtask

    task automatic test_part_aliasing;
        begin
            send_access(OP_WRITE, IDX_RAX, PART_QWORD, 64'h0123_4567_89AB_CDEF);
            send_access(OP_WRITE, IDX_RAX, PART_LOW_BYTE, ALL_ONES);
            send_access(OP_WRITE, IDX_RAX, PART_HIGH_BYTE, '0);
            send_access(OP_READ, IDX_RAX, PART_LOW_BYTE, '0);
            send_access(OP_READ, IDX_RAX, PART_HIGH_BYTE, '0);
            send_access(OP_READ, IDX_RAX, PART_WORD, '0);
            send_access(OP_READ, IDX_RAX, PART_DWORD, '0);
            send_access(OP_READ, IDX_RAX, PART_QWORD, '0);
            send_access(OP_WRITE, IDX_RAX, PART_DWORD, 64'hFFFF_FFFF_8000_0001);
            send_access(OP_READ, IDX_RAX, PART_QWORD, '0);
            send_access(OP_WRITE, IDX_RBX, PART_WORD, 64'hAAAA_AAAA_AAAA_5555);
            send_access(OP_READ, IDX_RBX, PART_QWORD, '0);
        end
    endtask

    task automatic test_value_extremes;
        begin
            send_access(OP_WRITE, IDX_R15, PART_QWORD, ALL_ONES);
            send_access(OP_READ, IDX_R15, PART_QWORD, '0);
            send_access(OP_WRITE, IDX_RIP, PART_QWORD, ALL_ONES);
            send_access(OP_WRITE, IDX_RIP, PART_DWORD, '0);
            send_access(OP_READ, IDX_RIP, PART_WORD, '0);
        end
    endtask

    task automatic test_invalid_pairs;
        begin
            send_access(OP_WRITE, IDX_R8, PART_HIGH_BYTE, ALL_ONES);
            send_access(OP_READ, IDX_RSP, PART_HIGH_BYTE, '0);
            send_access(OP_READ, IDX_RIP, PART_LOW_BYTE, '0);
            send_access(OP_WRITE, IDX_RIP, PART_HIGH_BYTE, ALL_ONES);
            send_access(OP_READ, IDX_R8, PART_QWORD, '0);
        end
    endtask

    task automatic test_clear_all;
        begin
            send_access(OP_CLEAR, IDX_R15, PART_HIGH_BYTE, ALL_ONES);
            send_access(OP_READ, IDX_RAX, PART_QWORD, '0);
            send_access(OP_READ, IDX_R15, PART_QWORD, '0);
        end
    endtask

    task automatic test_random_accesses(input int count);
        int                n;
        int                pick;
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] val;
        begin
            for (n = 0; n < count; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 2)
                    op = OP_CLEAR;
                else if (pick < 51)
                    op = OP_READ;
                else
                    op = OP_WRITE;
                pick = $urandom_range(9);
                if (pick == 0)
                    val = '0;
                else if (pick == 1)
                    val = ALL_ONES;
                else
                    val = {$urandom, $urandom};
                send_access(op, IDX_W'($urandom_range(16)), PART_W'($urandom_range(4)), val);
            end
        end
    endtask

    initial
    begin
        error_count   = 0;
        send_idle_pct = 37;
        recv_idle_pct = 84;
        gpr_words     = '{default: '0};
        gpr_written   = '0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        operation   <= OP_READ;
        reg_index   <= '0;
        part        <= PART_QWORD;
        write_value <= '0;
        out_ready   <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_contents();
        test_part_aliasing();
        test_value_extremes();
        test_invalid_pairs();
        test_clear_all();
        test_random_accesses(400);
        wait_until_drained();

        send_idle_pct = 84;
        recv_idle_pct = 37;
        test_random_accesses(430);
        wait_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_accesses(450);
        wait_until_drained();
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
